[design/irdx_pkg.sv]
`default_nettype none

package irdx_pkg;

    localparam int RADIX_MAX   = 56;
    localparam int DIGITS_MAX  = 32;
    localparam int ALPHA_WORDS = 7;
    localparam int WORD_BYTES  = 8;

    localparam int RADIX_W = 6;
    localparam int DIGIT_W = 6;
    localparam int COUNT_W = 6;
    localparam int STORE_W = 5;
    localparam int INDEX_W = 3;
    localparam int DATA_W  = 64;
    localparam int VALUE_W = 32;

    localparam logic [INDEX_W-1:0] REG_BASE_LENGTH = 3'd0;
    localparam logic [INDEX_W-1:0] REG_ALPHA_FIRST = 3'd1;

    localparam logic [7:0] CHAR_MINUS   = 8'd45;
    localparam logic [7:0] CHAR_NUL     = 8'd0;
    localparam logic [7:0] DIGIT_LOW    = 8'd48;
    localparam logic [7:0] DIGIT_HIGH   = 8'd57;
    localparam logic [7:0] UPPER_LOW    = 8'd65;
    localparam logic [7:0] UPPER_HIGH   = 8'd90;
    localparam logic [7:0] LOWER_LOW    = 8'd97;
    localparam logic [7:0] LOWER_HIGH   = 8'd122;

    typedef logic [RADIX_MAX-1:0][7:0] alpha_t;
    typedef logic [DIGIT_W-1:0]        digit_t;

    typedef enum logic [6:0] {
        S_IDLE      = 7'b0000001,
        S_CHECK     = 7'b0000010,
        S_ERROR     = 7'b0000100,
        S_DIV_START = 7'b0001000,
        S_DIV_WAIT  = 7'b0010000,
        S_SIGN      = 7'b0100000,
        S_EMIT      = 7'b1000000
    } state_t;

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = (c >= DIGIT_LOW && c <= DIGIT_HIGH)
                || (c >= UPPER_LOW && c <= UPPER_HIGH)
                || (c >= LOWER_LOW && c <= LOWER_HIGH);
    endfunction

endpackage

`default_nettype wire

[design/signed_integer_to_radix_digits_core.sv]
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid, in_stall   value
// out       output     out_valid, out_stall out_char, last_char, bad_alphabet
// cfg       input      cfg_we               cfg_index, cfg_data
//
// One transaction checks the alphabet entries in turn, then computes each digit in the
// shared bit-serial divider, then emits one character per cycle unless the output
// is stalled. The block accepts a new input transaction only when idle; a finished
// character waits in the output register while the output is stalled.
// Reset clears the sequencer, counters and configuration registers.

module signed_integer_to_radix_digits_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic signed [31:0]              value,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [7:0]                           out_char,
    output logic                                 last_char,
    output logic                                 bad_alphabet,
    input  wire logic                            cfg_we,
    input  wire logic [irdx_pkg::INDEX_W-1:0]    cfg_index,
    input  wire logic [irdx_pkg::DATA_W-1:0]     cfg_data
);
    import irdx_pkg::*;

    state_t              state_reg, state_next;
    logic [RADIX_W-1:0]  base_length_reg;
    alpha_t              alpha_reg;
    logic [DIGIT_W-1:0]  idx_reg, idx_next;
    logic [VALUE_W-1:0]  mag_reg, mag_next;
    logic                neg_reg, neg_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    digit_t              digit_store [DIGITS_MAX];

    logic                out_valid_reg, out_valid_next;
    logic [7:0]          out_char_reg, out_char_next;
    logic                last_char_reg, last_char_next;
    logic                bad_reg, bad_next;

    logic                load_ok;
    logic                load;
    logic                entry_bad;
    logic                radix_bad;
    logic                div_start;
    logic                div_done;
    logic [VALUE_W-1:0]  div_quo;
    logic [RADIX_W-1:0]  div_rem;
    logic                store_we;
    logic [COUNT_W-1:0]  count_dec;
    logic [COUNT_W-1:0]  count_next_dec;
    digit_t              emit_digit_reg;

    irdx_divider u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (mag_reg),
        .divisor   (base_length_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    irdx_alpha_check u_check (
        .alphabet  (alpha_reg),
        .idx       (idx_reg),
        .entry_bad (entry_bad)
    );

    assign radix_bad  = (base_length_reg < RADIX_W'(2)) || (base_length_reg > RADIX_W'(RADIX_MAX));
    assign load_ok    = !out_valid_reg || !out_stall;
    assign count_dec  = count_reg - 1'b1;
    assign count_next_dec = count_next - 1'b1;
    assign div_start  = (state_reg == S_DIV_START);
    assign in_stall   = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        mag_next       = mag_reg;
        neg_next       = neg_reg;
        count_next     = count_reg;
        load           = 1'b0;
        out_char_next  = out_char_reg;
        last_char_next = last_char_reg;
        bad_next       = bad_reg;
        store_we       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = value[VALUE_W-1];
                    mag_next   = value[VALUE_W-1] ? (VALUE_W'(0) - value) : value;
                    idx_next   = '0;
                    count_next = '0;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (radix_bad || entry_bad)
                begin
                    state_next = S_ERROR;
                end
                else if (idx_reg == base_length_reg - 1'b1)
                begin
                    state_next = S_DIV_START;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_ERROR:
            begin
                if (load_ok)
                begin
                    load           = 1'b1;
                    out_char_next  = CHAR_NUL;
                    last_char_next = 1'b1;
                    bad_next       = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_DIV_START:
            begin
                state_next = S_DIV_WAIT;
            end
            S_DIV_WAIT:
            begin
                if (div_done)
                begin
                    store_we   = 1'b1;
                    mag_next   = div_quo;
                    count_next = count_reg + 1'b1;
                    if ((div_quo == '0) || (count_reg == COUNT_W'(DIGITS_MAX - 1)))
                    begin
                        state_next = neg_reg ? S_SIGN : S_EMIT;
                    end
                    else
                    begin
                        state_next = S_DIV_START;
                    end
                end
            end
            S_SIGN:
            begin
                if (load_ok)
                begin
                    load           = 1'b1;
                    out_char_next  = CHAR_MINUS;
                    last_char_next = 1'b0;
                    bad_next       = 1'b0;
                    state_next     = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (load_ok)
                begin
                    load           = 1'b1;
                    out_char_next  = alpha_reg[emit_digit_reg];
                    last_char_next = (count_reg == COUNT_W'(1));
                    bad_next       = 1'b0;
                    count_next     = count_dec;
                    if (count_reg == COUNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            idx_reg         <= '0;
            mag_reg         <= '0;
            neg_reg         <= 1'b0;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
            base_length_reg <= '0;
            alpha_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            mag_reg       <= mag_next;
            neg_reg       <= neg_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                if (cfg_index == REG_BASE_LENGTH)
                begin
                    base_length_reg <= cfg_data[RADIX_W-1:0];
                end
                for (int k = 0; k < ALPHA_WORDS; k++)
                begin
                    if (cfg_index == REG_ALPHA_FIRST + INDEX_W'(k))
                    begin
                        for (int b = 0; b < WORD_BYTES; b++)
                        begin
                            alpha_reg[k * WORD_BYTES + b] <= cfg_data[b * 8 +: 8];
                        end
                    end
                end
            end
        end
    end

    // The digit for the next character is fetched ahead into emit_digit_reg; a digit being
    // written in the same cycle is taken straight from the divider.
    always_ff @(posedge clk)
    begin
        out_char_reg  <= out_char_next;
        last_char_reg <= last_char_next;
        bad_reg       <= bad_next;
        if (store_we)
        begin
            digit_store[count_reg[STORE_W-1:0]] <= div_rem;
            emit_digit_reg <= div_rem;
        end
        else
        begin
            emit_digit_reg <= digit_store[count_next_dec[STORE_W-1:0]];
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = out_char_reg;
    assign last_char    = last_char_reg;
    assign bad_alphabet = bad_reg;

endmodule

`default_nettype wire

[design/irdx_divider.sv]
`default_nettype none

module irdx_divider (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic [irdx_pkg::VALUE_W-1:0]      dividend,
    input  wire logic [irdx_pkg::RADIX_W-1:0]      divisor,
    output logic                                   done,
    output logic [irdx_pkg::VALUE_W-1:0]           quotient,
    output logic [irdx_pkg::RADIX_W-1:0]           remainder
);
    import irdx_pkg::*;

    localparam int CNT_W = $clog2(VALUE_W);

    logic                 busy_reg;
    logic                 done_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [VALUE_W-1:0]   quo_reg;
    logic [RADIX_W-1:0]   rem_reg;
    logic [RADIX_W-1:0]   divisor_reg;
    logic [RADIX_W:0]     trial;
    logic [RADIX_W:0]     diff;
    logic                 ge;
    logic [RADIX_W-1:0]   rem_next;
    logic [VALUE_W-1:0]   quo_next;

    // One restoring step per cycle, quotient bits shift in from the bottom.
    always_comb
    begin
        trial    = {rem_reg, quo_reg[VALUE_W-1]};
        diff     = trial - {1'b0, divisor_reg};
        ge       = trial >= {1'b0, divisor_reg};
        rem_next = ge ? diff[RADIX_W-1:0] : trial[RADIX_W-1:0];
        quo_next = {quo_reg[VALUE_W-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(VALUE_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg     <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

[design/irdx_alpha_check.sv]
`default_nettype none

module irdx_alpha_check (
    input  wire irdx_pkg::alpha_t              alphabet,
    input  wire logic [irdx_pkg::DIGIT_W-1:0]  idx,
    output logic                               entry_bad
);
    import irdx_pkg::*;

    logic [7:0] c;
    logic       dup;

    // The selected character is compared against every earlier character at once.
    always_comb
    begin
        c   = alphabet[idx];
        dup = 1'b0;
        for (int j = 0; j < RADIX_MAX; j++)
        begin
            if ((DIGIT_W'(j) < idx) && (alphabet[j] == c))
            begin
                dup = 1'b1;
            end
        end
        entry_bad = dup || !is_alnum(c);
    end

endmodule

`default_nettype wire

[dv/signed_integer_to_radix_digits_core_tb.sv]
`timescale 1ns / 100ps

module signed_integer_to_radix_digits_core_tb;
    import irdx_pkg::*;

    localparam int IDLE_LIMIT      = 6000;
    localparam int GAP_PERCENT     = 24;
    localparam int ITEMS_PER_PHASE = 25;
    localparam int RANDOM_PHASES   = 12;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 4;
    localparam int DRAIN_CYCLES    = 50;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
        logic       bad;
    } text_char_t;

    typedef logic [ALPHA_WORDS-1:0][DATA_W-1:0] alpha_words_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic signed [31:0]     value;
    logic                   out_valid;
    logic                   out_stall;
    logic [7:0]             out_char;
    logic                   last_char;
    logic                   bad_alphabet;
    logic                   cfg_we;
    logic [INDEX_W-1:0]     cfg_index;
    logic [DATA_W-1:0]      cfg_data;

    logic [RADIX_W-1:0]     model_radix = '0;
    alpha_words_t           model_words = '0;
    text_char_t             pending_chars[$];

    logic                   gaps_on = 1'b1;
    int                     hold_cycles = 0;
    int                     quiet_cycles = 0;
    int                     mismatches = 0;

    signed_integer_to_radix_digits_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .last_char    (last_char),
        .bad_alphabet (bad_alphabet),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic logic letter_or_digit(input logic [7:0] c);
        return (c >= DIGIT_LOW && c <= DIGIT_HIGH) || (c >= UPPER_LOW && c <= UPPER_HIGH)
            || (c >= LOWER_LOW && c <= LOWER_HIGH);
    endfunction

    function automatic logic [7:0] char_at(input alpha_words_t words, input int idx);
        return words[(idx / WORD_BYTES) % ALPHA_WORDS][(idx % WORD_BYTES) * 8 +: 8];
    endfunction

    function automatic alpha_words_t replace_char(input alpha_words_t words, input int idx,
                                                  input logic [7:0] c);
        alpha_words_t result;
        result = words;
        result[idx / WORD_BYTES][(idx % WORD_BYTES) * 8 +: 8] = c;
        return result;
    endfunction

    // The first len bytes come from the letters and digits, in their natural order
    // or shuffled; every other byte is random.
    function automatic alpha_words_t make_alphabet(input int len, input logic shuffle);
        logic [7:0]   pool[62];
        alpha_words_t words;
        int           k;
        int           pick;
        logic [7:0]   tmp;
        k = 0;
        for (int c = 0; c < 256; c++)
        begin
            if (letter_or_digit(8'(c)))
            begin
                pool[k] = 8'(c);
                k++;
            end
        end
        for (int w = 0; w < ALPHA_WORDS; w++)
            words[w] = {$urandom, $urandom};
        for (int i = 0; i < len && i < RADIX_MAX; i++)
        begin
            if (shuffle)
            begin
                pick = $urandom_range(61, i);
                tmp = pool[i];
                pool[i] = pool[pick];
                pool[pick] = tmp;
            end
            words = replace_char(words, i, pool[i]);
        end
        return words;
    endfunction

    function automatic logic alphabet_usable();
        int         n;
        logic [7:0] c;
        n = int'(model_radix);
        if (n < 2 || n > RADIX_MAX)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            c = char_at(model_words, i);
            if (!letter_or_digit(c))
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (char_at(model_words, j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_text(input logic [31:0] raw);
        logic [31:0] magnitude;
        logic [31:0] radix;
        digit_t      digits[DIGITS_MAX];
        int          count;
        if (!alphabet_usable())
        begin
            pending_chars.push_back(text_char_t'{ch: CHAR_NUL, last: 1'b1, bad: 1'b1});
            return;
        end
        radix = 32'(model_radix);
        magnitude = raw[31] ? 32'd0 - raw : raw;
        count = 0;
        do
        begin
            digits[count] = digit_t'(magnitude % radix);
            magnitude = magnitude / radix;
            count++;
        end
        while (magnitude != 0 && count < DIGITS_MAX);
        if (raw[31])
            pending_chars.push_back(text_char_t'{ch: CHAR_MINUS, last: 1'b0, bad: 1'b0});
        for (int d = count - 1; d >= 0; d--)
            pending_chars.push_back(text_char_t'{ch: char_at(model_words, int'(digits[d])),
                                                 last: (d == 0), bad: 1'b0});
    endfunction

    function automatic logic [31:0] pick_value(input int radix);
        logic [31:0] p;
        logic [31:0] r;
        int          k;
        r = (radix < 2) ? 32'd10 : 32'(radix);
        case ($urandom_range(9))
            0: return 32'd0;
            1: return 32'h8000_0000;
            2: return 32'h7fff_ffff;
            3:
            begin
                p = $urandom_range(r * r);
                return $urandom_range(1) ? p : 32'd0 - p;
            end
            4:
            begin
                p = 32'd1;
                k = $urandom_range(31, 1);
                repeat (k)
                    if (p <= 32'hffff_ffff / r)
                        p = p * r;
                p = p + $urandom_range(2) - 1;
                return $urandom_range(1) ? p : 32'd0 - p;
            end
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_alphabet(input int len, input alpha_words_t words);
        wait_idle();
        for (int i = 0; i <= ALPHA_WORDS; i++)
        begin
            cfg_we <= 1'b1;
            if (i == 0)
            begin
                cfg_index <= REG_BASE_LENGTH;
                cfg_data <= DATA_W'(len);
            end
            else
            begin
                cfg_index <= REG_ALPHA_FIRST + INDEX_W'(i - 1);
                cfg_data <= words[i - 1];
            end
            @(posedge clk);
            if (i == 0)
                model_radix = RADIX_W'(len);
            else
                model_words[i - 1] = words[i - 1];
        end
        cfg_we <= 1'b0;
    endtask

    task automatic send_value(input logic [31:0] v);
        while (gaps_on && $urandom_range(99) < GAP_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value <= v;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_text(v);
    endtask

    task automatic test_decimal_basics();
        load_alphabet(10, make_alphabet(10, 1'b0));
        send_value(32'd0);
        send_value(32'd10);
        send_value(32'hffff_ffff);
        send_value(32'h7fff_ffff);
        send_value(32'h8000_0000);
    endtask

    task automatic test_radix_extremes();
        alpha_words_t words;
        load_alphabet(2, make_alphabet(2, 1'b0));
        send_value(32'h8000_0000);
        send_value(32'hffff_ffff);
        send_value(32'h7fff_ffff);
        load_alphabet(RADIX_MAX, make_alphabet(RADIX_MAX, 1'b1));
        send_value(32'd55);
        send_value(32'd56);
        send_value(32'h8000_0000);
        words = make_alphabet(0, 1'b0);
        words[0][47:0] = "zaZA90";
        load_alphabet(6, words);
        send_value(32'd35);
        send_value(32'hffff_ffdc);
        // A byte past the configured length is never looked at.
        load_alphabet(12, replace_char(make_alphabet(12, 1'b0), 12, CHAR_MINUS));
        send_value(32'd12345);
    endtask

    task automatic test_bad_alphabets();
        logic [7:0] bad_chars[6];
        bad_chars = '{8'd47, 8'd58, 8'd64, 8'd91, 8'd96, 8'd123};
        load_alphabet(0, make_alphabet(10, 1'b0));
        send_value(32'd0);
        load_alphabet(1, make_alphabet(10, 1'b0));
        send_value(32'h8000_0000);
        load_alphabet(RADIX_MAX + 1, make_alphabet(RADIX_MAX, 1'b0));
        send_value(32'hffff_ffff);
        load_alphabet(63, make_alphabet(RADIX_MAX, 1'b0));
        send_value(32'd123);
        load_alphabet(10, replace_char(make_alphabet(10, 1'b0), 9, DIGIT_LOW));
        send_value(32'd77);
        foreach (bad_chars[i])
        begin
            load_alphabet(12, replace_char(make_alphabet(12, 1'b0), (i % 2) ? 11 : 0,
                                           bad_chars[i]));
            send_value($urandom);
        end
    endtask

    task automatic test_random_conversions();
        alpha_words_t words;
        int           len;
        int           spot;
        int           other;
        logic [7:0]   c;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: len = 2;
                1: len = RADIX_MAX;
                default: len = $urandom_range(RADIX_MAX - 1, 3);
            endcase
            words = make_alphabet(len, 1'b1);
            if (phase % 4 == 2)
            begin
                case ($urandom_range(2))
                    0:
                    begin
                        spot = $urandom_range(len - 1, 1);
                        other = $urandom_range(spot - 1);
                        words = replace_char(words, spot, char_at(words, other));
                    end
                    1:
                    begin
                        do
                            c = 8'($urandom_range(255));
                        while (letter_or_digit(c));
                        words = replace_char(words, $urandom_range(len - 1), c);
                    end
                    default:
                        len = $urandom_range(1) ? $urandom_range(1)
                                                : $urandom_range(63, RADIX_MAX + 1);
                endcase
            end
            load_alphabet(len, words);
            gaps_on = (phase != 5);
            repeat (ITEMS_PER_PHASE) send_value(pick_value(len));
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        load_alphabet(16, make_alphabet(16, 1'b0));
        hold_cycles = HOLD_OFF_CYCLES;
        repeat (6) send_value($urandom);
    endtask

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_stall <= 1'b1;
            hold_cycles--;
        end
        else
        begin
            out_stall <= gaps_on && ($urandom_range(99) < GAP_PERCENT);
        end
    end

    always @(posedge clk)
    begin : check_text
        text_char_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_chars.size() == 0)
            begin
                $error("unexpected transaction: out_char %0d", out_char);
                mismatches++;
            end
            else
            begin
                want = pending_chars.pop_front();
                if (out_char !== want.ch)
                begin
                    $error("out_char: expected %0d, actual %0d", want.ch, out_char);
                    mismatches++;
                end
                if (last_char !== want.last)
                begin
                    $error("last_char: expected %0d, actual %0d", want.last, last_char);
                    mismatches++;
                end
                if (bad_alphabet !== want.bad)
                begin
                    $error("bad_alphabet: expected %0d, actual %0d", want.bad, bad_alphabet);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        value <= '0;
        out_stall <= 1'b0;
        cfg_we <= 1'b0;
        cfg_index <= REG_BASE_LENGTH;
        cfg_data <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        test_decimal_basics();
        test_radix_extremes();
        test_bad_alphabets();
        test_random_conversions();
        test_output_backpressure();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

[signed_integer_to_radix_digits_core.f]
design/irdx_pkg.sv
design/irdx_divider.sv
design/irdx_alpha_check.sv
design/signed_integer_to_radix_digits_core.sv
dv/signed_integer_to_radix_digits_core_tb.sv
